[src/gdda_pkg.sv]
// shared types and constants of the grid ray traversal block
package gdda_pkg;

   localparam int POS_W      = 12;
   localparam int FRAC_W     = 9;
   localparam int DIST_W     = 16;
   localparam int IDX_W      = 8;
   localparam int CELL_OUT_W = 4;
   localparam int QUAD_W     = 2;

   // item kinds
   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_CAST  = 1'b1;

   // crossed grid line of a hit
   localparam logic SIDE_X = 1'b0;
   localparam logic SIDE_Y = 1'b1;

   // quadrant bits
   localparam int QUAD_X_POS_BIT = 1;
   localparam int QUAD_Y_POS_BIT = 0;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MUL_X,
      ST_MUL_Y,
      ST_WALK,
      ST_DONE
   } state_type;

endpackage

[src/grid_ray_dda_traversal_top.sv]
// grid ray traversal top: wall map, setup multiply and step walker
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------------
//  req     | in        | req_valid/stall   | kind, cell, wall, pos, fractions, steps, quad
//  rsp     | out       | rsp_valid/stall   | hit, side, distance, cell x, cell y
//
// a write item is taken in the idle state; a cast item holds the input with req_stall
// high through MUL_X, MUL_Y, WALK and DONE, and the walk enters at most MAX_STEPS cells
// the walk enters one cell per cycle: the map read of one step overlaps the
// next step, which is dropped if the returned cell is a wall
// after reset a clearing pass zeroes all GRID_SIZE * GRID_SIZE cells of the map,
// with req_stall high throughout
// a finished result waits in the rsp register; the next item is still taken,
// but a cast that ends while that result still waits holds with req_stall high
module grid_ray_dda_traversal_top #(
   parameter int GRID_SIZE = 16,
   parameter int FRAC_BITS = 8,
   parameter int MAX_STEPS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic [gdda_pkg::IDX_W-1:0]          req_cell_index,
   input  logic                                req_cell_wall,
   input  logic [gdda_pkg::POS_W-1:0]          req_pos_x,
   input  logic [gdda_pkg::POS_W-1:0]          req_pos_y,
   input  logic [gdda_pkg::FRAC_W-1:0]         req_frac_x_neg,
   input  logic [gdda_pkg::FRAC_W-1:0]         req_frac_x_pos,
   input  logic [gdda_pkg::FRAC_W-1:0]         req_frac_y_neg,
   input  logic [gdda_pkg::FRAC_W-1:0]         req_frac_y_pos,
   input  logic [gdda_pkg::DIST_W-1:0]         req_step_dist_x,
   input  logic [gdda_pkg::DIST_W-1:0]         req_step_dist_y,
   input  logic [gdda_pkg::QUAD_W-1:0]         req_quadrant,
   // result items
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_hit,
   output logic                                rsp_hit_side,
   output logic [gdda_pkg::DIST_W-1:0]         rsp_hit_distance,
   output logic [gdda_pkg::CELL_OUT_W-1:0]     rsp_hit_cell_x,
   output logic [gdda_pkg::CELL_OUT_W-1:0]     rsp_hit_cell_y
);

   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CW         = $clog2(GRID_SIZE);
   localparam int SW         = $clog2(MAX_STEPS + 1);
   localparam int CNT_W      = $clog2(CELL_COUNT + 1);
   localparam int CMP_W      = (CNT_W > gdda_pkg::IDX_W) ? CNT_W : gdda_pkg::IDX_W;
   localparam int MOD_W      = 16;
   localparam int MOD_STEPS  = 8;

   // fsm
   gdda_pkg::state_type state_ff, state_in;

   // clearing pass
   logic [AW-1:0] clr_ff, clr_in;
   logic          clr_last;

   // ray setup
   logic [gdda_pkg::FRAC_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic [gdda_pkg::DIST_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic                        xpos_ff, xpos_in, ypos_ff, ypos_in;

   // walk cursor
   logic [gdda_pkg::DIST_W-1:0] sx_ff, sx_in, sy_ff, sy_in;
   logic [CW-1:0]               mx_ff, mx_in, my_ff, my_in;
   logic [SW-1:0]               steps_ff, steps_in;

   // step whose map read is in flight
   logic                        pend_valid_ff, pend_valid_in;
   logic                        pend_side_ff, pend_side_in;
   logic [gdda_pkg::DIST_W-1:0] pend_dist_ff, pend_dist_in;
   logic [CW-1:0]               pend_cx_ff, pend_cx_in, pend_cy_ff, pend_cy_in;
   logic                        res_hit_ff, res_hit_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_hit_ff, rsp_hit_in;
   logic                            rsp_side_ff, rsp_side_in;
   logic [gdda_pkg::DIST_W-1:0]     rsp_dist_ff, rsp_dist_in;
   logic [gdda_pkg::CELL_OUT_W-1:0] rsp_cx_ff, rsp_cx_in, rsp_cy_ff, rsp_cy_in;

   // combinational
   logic                        req_acc;
   logic                        rsp_free;
   logic                        wr_in_range;
   logic                        mem_wr_en;
   logic [AW-1:0]               mem_wr_addr;
   logic                        mem_wr_data;
   logic [AW-1:0]               mem_rd_addr;
   logic                        mem_rd_data;
   logic [gdda_pkg::FRAC_W-1:0] scale_frac;
   logic [gdda_pkg::DIST_W-1:0] scale_dist;
   logic [gdda_pkg::DIST_W-1:0] scale_out;
   logic [MOD_W-1:0]            cell_x_mod, cell_y_mod;
   logic                        take_x;
   logic [CW-1:0]               next_cx, next_cy, step_cx, step_cy;
   logic                        pend_hit;
   logic                        walk_fin;
   logic                        walk_issue;

   gdda_map #(
      .DEPTH (CELL_COUNT),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // one multiplier shared by both axes, x in state MUL_X and y in state MUL_Y
   gdda_scale #(
      .FRAC_BITS (FRAC_BITS)
   ) u_scale (
      .frac      (scale_frac),
      .step_dist (scale_dist),
      .scaled    (scale_out)
   );

   assign scale_frac = (state_ff == gdda_pkg::ST_MUL_X) ? fx_ff : fy_ff;
   assign scale_dist = (state_ff == gdda_pkg::ST_MUL_X) ? dx_ff : dy_ff;

   // start cell: integer part of the position, wrapped into the grid by
   // restoring subtraction of shifted grid sizes
   always_comb begin
      cell_x_mod = MOD_W'(req_pos_x >> FRAC_BITS);
      cell_y_mod = MOD_W'(req_pos_y >> FRAC_BITS);
      for (int k = MOD_STEPS - 1; k >= 0; k--) begin
         if (cell_x_mod >= (MOD_W'(GRID_SIZE) << k)) begin
            cell_x_mod = cell_x_mod - (MOD_W'(GRID_SIZE) << k);
         end
         if (cell_y_mod >= (MOD_W'(GRID_SIZE) << k)) begin
            cell_y_mod = cell_y_mod - (MOD_W'(GRID_SIZE) << k);
         end
      end
   end

   // step decision, ties go to y
   assign take_x  = sx_ff < sy_ff;
   assign next_cx = xpos_ff ? ((mx_ff == CW'(GRID_SIZE - 1)) ? '0 : mx_ff + 1'b1)
                            : ((mx_ff == '0) ? CW'(GRID_SIZE - 1) : mx_ff - 1'b1);
   assign next_cy = ypos_ff ? ((my_ff == CW'(GRID_SIZE - 1)) ? '0 : my_ff + 1'b1)
                            : ((my_ff == '0) ? CW'(GRID_SIZE - 1) : my_ff - 1'b1);
   assign step_cx = take_x ? next_cx : mx_ff;
   assign step_cy = take_x ? my_ff : next_cy;

   assign mem_rd_addr = AW'(step_cy) * AW'(GRID_SIZE) + AW'(step_cx);

   assign pend_hit = pend_valid_ff && mem_rd_data;
   assign walk_fin = pend_hit || (steps_ff == SW'(MAX_STEPS));

   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign clr_last    = clr_ff == AW'(CELL_COUNT - 1);
   assign wr_in_range = CMP_W'(req_cell_index) < CMP_W'(CELL_COUNT);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdda_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = gdda_pkg::ST_IDLE;
            end
         end
         gdda_pkg::ST_IDLE: begin
            if (req_valid && req_kind == gdda_pkg::KIND_CAST) begin
               state_in = gdda_pkg::ST_MUL_X;
            end
         end
         gdda_pkg::ST_MUL_X: state_in = gdda_pkg::ST_MUL_Y;
         gdda_pkg::ST_MUL_Y: state_in = gdda_pkg::ST_WALK;
         gdda_pkg::ST_WALK: begin
            if (walk_fin) begin
               state_in = gdda_pkg::ST_DONE;
            end
         end
         gdda_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = gdda_pkg::ST_IDLE;
            end
         end
         default: state_in = gdda_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      req_stall   = 1'b1;
      req_acc     = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_ff;
      mem_wr_data = 1'b0;
      walk_issue  = 1'b0;
      unique case (state_ff)
         gdda_pkg::ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         gdda_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            req_acc   = req_valid;
            if (req_valid && req_kind == gdda_pkg::KIND_WRITE && wr_in_range) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = AW'(req_cell_index);
               mem_wr_data = req_cell_wall;
            end
         end
         gdda_pkg::ST_WALK: begin
            walk_issue = !walk_fin;
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in        = clr_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      xpos_in       = xpos_ff;
      ypos_in       = ypos_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      mx_in         = mx_ff;
      my_in         = my_ff;
      steps_in      = steps_ff;
      pend_valid_in = pend_valid_ff;
      pend_side_in  = pend_side_ff;
      pend_dist_in  = pend_dist_ff;
      pend_cx_in    = pend_cx_ff;
      pend_cy_in    = pend_cy_ff;
      res_hit_in    = res_hit_ff;

      if (state_ff == gdda_pkg::ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end

      if (req_acc && req_kind == gdda_pkg::KIND_CAST) begin
         xpos_in = req_quadrant[gdda_pkg::QUAD_X_POS_BIT];
         ypos_in = req_quadrant[gdda_pkg::QUAD_Y_POS_BIT];
         fx_in   = req_quadrant[gdda_pkg::QUAD_X_POS_BIT] ? req_frac_x_pos : req_frac_x_neg;
         fy_in   = req_quadrant[gdda_pkg::QUAD_Y_POS_BIT] ? req_frac_y_pos : req_frac_y_neg;
         dx_in   = req_step_dist_x;
         dy_in   = req_step_dist_y;
         mx_in   = CW'(cell_x_mod);
         my_in   = CW'(cell_y_mod);
      end

      if (state_ff == gdda_pkg::ST_MUL_X) begin
         sx_in = scale_out;
      end

      if (state_ff == gdda_pkg::ST_MUL_Y) begin
         sy_in         = scale_out;
         steps_in      = '0;
         pend_valid_in = 1'b0;
      end

      if (walk_issue) begin
         // advance as if the entered cell is empty; dropped on a hit
         pend_valid_in = 1'b1;
         pend_cx_in    = step_cx;
         pend_cy_in    = step_cy;
         steps_in      = steps_ff + 1'b1;
         mx_in         = step_cx;
         my_in         = step_cy;
         if (take_x) begin
            pend_side_in = gdda_pkg::SIDE_X;
            pend_dist_in = sx_ff;
            sx_in        = sx_ff + dx_ff;
         end else begin
            pend_side_in = gdda_pkg::SIDE_Y;
            pend_dist_in = sy_ff;
            sy_in        = sy_ff + dy_ff;
         end
      end

      if (state_ff == gdda_pkg::ST_WALK && walk_fin) begin
         res_hit_in = pend_hit;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_side_in  = rsp_side_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_cx_in    = rsp_cx_ff;
      rsp_cy_in    = rsp_cy_ff;
      if (state_ff == gdda_pkg::ST_DONE && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = res_hit_ff;
         // a miss reports all fields zero
         rsp_side_in  = res_hit_ff ? pend_side_ff : gdda_pkg::SIDE_X;
         rsp_dist_in  = res_hit_ff ? pend_dist_ff : '0;
         rsp_cx_in    = res_hit_ff ? gdda_pkg::CELL_OUT_W'(pend_cx_ff) : '0;
         rsp_cy_in    = res_hit_ff ? gdda_pkg::CELL_OUT_W'(pend_cy_ff) : '0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gdda_pkg::ST_CLEAR;
         clr_ff        <= '0;
         steps_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         steps_ff      <= steps_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fx_ff        <= fx_in;
      fy_ff        <= fy_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      xpos_ff      <= xpos_in;
      ypos_ff      <= ypos_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      mx_ff        <= mx_in;
      my_ff        <= my_in;
      pend_side_ff <= pend_side_in;
      pend_dist_ff <= pend_dist_in;
      pend_cx_ff   <= pend_cx_in;
      pend_cy_ff   <= pend_cy_in;
      res_hit_ff   <= res_hit_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_side_ff  <= rsp_side_in;
      rsp_dist_ff  <= rsp_dist_in;
      rsp_cx_ff    <= rsp_cx_in;
      rsp_cy_ff    <= rsp_cy_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_side     = rsp_side_ff;
   assign rsp_hit_distance = rsp_dist_ff;
   assign rsp_hit_cell_x   = rsp_cx_ff;
   assign rsp_hit_cell_y   = rsp_cy_ff;

`ifndef NO_ASSERTIONS
   // the walk never issues more than the step limit
   a_steps_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdda_pkg::ST_WALK |-> steps_ff <= SW'(MAX_STEPS))
      else $error("walk step count beyond limit");

   // the map is not written while a ray is being walked
   a_no_write_in_walk: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdda_pkg::ST_WALK |-> !mem_wr_en)
      else $error("map write during walk");

   // the cursor stays inside the grid
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      state_ff == gdda_pkg::ST_WALK |->
         (mx_ff <= CW'(GRID_SIZE - 1)) && (my_ff <= CW'(GRID_SIZE - 1)))
      else $error("walk cursor outside grid");

   // a new result only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == gdda_pkg::ST_DONE)
      else $error("result raised outside done state");
`endif

endmodule

[src/gdda_map.sv]
// wall map memory, one write port and one registered read port
module gdda_map #(
   parameter int DEPTH = 256,
   parameter int AW    = 8
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/gdda_scale.sv]
// initial side distance: (frac * step distance) >> FRAC_BITS, kept to 16 bits
module gdda_scale #(
   parameter int FRAC_BITS = 8
) (
   input  logic [gdda_pkg::FRAC_W-1:0] frac,
   input  logic [gdda_pkg::DIST_W-1:0] step_dist,
   output logic [gdda_pkg::DIST_W-1:0] scaled
);

   localparam int PROD_W = gdda_pkg::FRAC_W + gdda_pkg::DIST_W;

   logic [PROD_W-1:0] prod;

   assign prod   = PROD_W'(frac) * PROD_W'(step_dist);
   assign scaled = gdda_pkg::DIST_W'(prod >> FRAC_BITS);

endmodule

[bench/tb_grid_ray_dda_traversal_top.sv]
// self-checking testbench of the grid ray traversal block: directed walls, random traffic, stalls
module tb_grid_ray_dda_traversal_top;

   // block configuration, kept at the defaults of the top level
   localparam int GRID_SIZE  = 16;
   localparam int FRAC_BITS  = 8;
   localparam int MAX_STEPS  = 16;
   localparam int CELL_COUNT = GRID_SIZE * GRID_SIZE;

   // cycles with no item moving on either channel before the run is called hung
   // (the clearing pass, the receiver hold of HOLD_CYCLES, long random stalls)
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 100;

   // direction quadrants, built from the quadrant bit positions of the package
   localparam logic [gdda_pkg::QUAD_W-1:0] TOWARD_XN_YN = '0;
   localparam logic [gdda_pkg::QUAD_W-1:0] TOWARD_XN_YP =
      gdda_pkg::QUAD_W'(1 << gdda_pkg::QUAD_Y_POS_BIT);
   localparam logic [gdda_pkg::QUAD_W-1:0] TOWARD_XP_YN =
      gdda_pkg::QUAD_W'(1 << gdda_pkg::QUAD_X_POS_BIT);
   localparam logic [gdda_pkg::QUAD_W-1:0] TOWARD_XP_YP = TOWARD_XN_YP | TOWARD_XP_YN;

   // one input item, all fields at port widths
   typedef struct packed {
      logic                            kind;
      logic [gdda_pkg::IDX_W-1:0]      cell_index;
      logic                            cell_wall;
      logic [gdda_pkg::POS_W-1:0]      pos_x;
      logic [gdda_pkg::POS_W-1:0]      pos_y;
      logic [gdda_pkg::FRAC_W-1:0]     frac_x_neg;
      logic [gdda_pkg::FRAC_W-1:0]     frac_x_pos;
      logic [gdda_pkg::FRAC_W-1:0]     frac_y_neg;
      logic [gdda_pkg::FRAC_W-1:0]     frac_y_pos;
      logic [gdda_pkg::DIST_W-1:0]     step_dist_x;
      logic [gdda_pkg::DIST_W-1:0]     step_dist_y;
      logic [gdda_pkg::QUAD_W-1:0]     quadrant;
   } ray_item_type;

   // outcome of one cast
   typedef struct packed {
      logic                            hit;
      logic                            hit_side;
      logic [gdda_pkg::DIST_W-1:0]     hit_distance;
      logic [gdda_pkg::CELL_OUT_W-1:0] hit_cell_x;
      logic [gdda_pkg::CELL_OUT_W-1:0] hit_cell_y;
   } ray_hit_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic                            req_kind;
   logic [gdda_pkg::IDX_W-1:0]      req_cell_index;
   logic                            req_cell_wall;
   logic [gdda_pkg::POS_W-1:0]      req_pos_x;
   logic [gdda_pkg::POS_W-1:0]      req_pos_y;
   logic [gdda_pkg::FRAC_W-1:0]     req_frac_x_neg;
   logic [gdda_pkg::FRAC_W-1:0]     req_frac_x_pos;
   logic [gdda_pkg::FRAC_W-1:0]     req_frac_y_neg;
   logic [gdda_pkg::FRAC_W-1:0]     req_frac_y_pos;
   logic [gdda_pkg::DIST_W-1:0]     req_step_dist_x;
   logic [gdda_pkg::DIST_W-1:0]     req_step_dist_y;
   logic [gdda_pkg::QUAD_W-1:0]     req_quadrant;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_hit;
   logic                            rsp_hit_side;
   logic [gdda_pkg::DIST_W-1:0]     rsp_hit_distance;
   logic [gdda_pkg::CELL_OUT_W-1:0] rsp_hit_cell_x;
   logic [gdda_pkg::CELL_OUT_W-1:0] rsp_hit_cell_y;

   // bench copy of the wall map, updated as write items are accepted
   logic        wall_cells [CELL_COUNT];
   // predicted outcomes of accepted casts, oldest first
   ray_hit_type outcomes_due [$];

   // idling knobs, percent chance per item or cycle
   int send_gap_pct;
   int stall_pct;
   // long receiver hold requested by the back-pressure test
   int hold_cycles;

   int n_writes;
   int n_casts;
   int n_results;
   int n_hits;
   int n_errors;
   int idle_cycles;

   grid_ray_dda_traversal_top #(
      .GRID_SIZE (GRID_SIZE),
      .FRAC_BITS (FRAC_BITS),
      .MAX_STEPS (MAX_STEPS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_cell_index   (req_cell_index),
      .req_cell_wall    (req_cell_wall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_frac_x_neg   (req_frac_x_neg),
      .req_frac_x_pos   (req_frac_x_pos),
      .req_frac_y_neg   (req_frac_y_neg),
      .req_frac_y_pos   (req_frac_y_pos),
      .req_step_dist_x  (req_step_dist_x),
      .req_step_dist_y  (req_step_dist_y),
      .req_quadrant     (req_quadrant),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_hit          (rsp_hit),
      .rsp_hit_side     (rsp_hit_side),
      .rsp_hit_distance (rsp_hit_distance),
      .rsp_hit_cell_x   (rsp_hit_cell_x),
      .rsp_hit_cell_y   (rsp_hit_cell_y)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor: walk the bench map the way the block should
   // ------------------------------------------------------------------

   function automatic ray_hit_type trace_ray(input ray_item_type it);
      ray_hit_type                                  res;
      logic                                         x_up;
      logic                                         y_up;
      logic [gdda_pkg::FRAC_W-1:0]                  frac_x;
      logic [gdda_pkg::FRAC_W-1:0]                  frac_y;
      logic [gdda_pkg::FRAC_W+gdda_pkg::DIST_W-1:0] prod_x;
      logic [gdda_pkg::FRAC_W+gdda_pkg::DIST_W-1:0] prod_y;
      logic [gdda_pkg::DIST_W-1:0]                  side_x;
      logic [gdda_pkg::DIST_W-1:0]                  side_y;
      int                                           col;
      int                                           row;
      res    = '0;
      x_up   = it.quadrant[gdda_pkg::QUAD_X_POS_BIT];
      y_up   = it.quadrant[gdda_pkg::QUAD_Y_POS_BIT];
      frac_x = x_up ? it.frac_x_pos : it.frac_x_neg;
      frac_y = y_up ? it.frac_y_pos : it.frac_y_neg;
      // scaled start distances, truncated to the distance width
      prod_x = frac_x * it.step_dist_x;
      prod_y = frac_y * it.step_dist_y;
      side_x = gdda_pkg::DIST_W'(prod_x >> FRAC_BITS);
      side_y = gdda_pkg::DIST_W'(prod_y >> FRAC_BITS);
      // start cell wraps into the grid
      col = (int'(it.pos_x) >> FRAC_BITS) % GRID_SIZE;
      row = (int'(it.pos_y) >> FRAC_BITS) % GRID_SIZE;
      for (int n = 0; n < MAX_STEPS; n++) begin
         // strictly smaller x side steps x, ties go to y
         if (side_x < side_y) begin
            col = x_up ? (col + 1) % GRID_SIZE : (col + GRID_SIZE - 1) % GRID_SIZE;
            if (wall_cells[row * GRID_SIZE + col]) begin
               res.hit          = 1'b1;
               res.hit_side     = gdda_pkg::SIDE_X;
               res.hit_distance = side_x;
               res.hit_cell_x   = gdda_pkg::CELL_OUT_W'(col);
               res.hit_cell_y   = gdda_pkg::CELL_OUT_W'(row);
               return res;
            end
            side_x = side_x + it.step_dist_x;
         end else begin
            row = y_up ? (row + 1) % GRID_SIZE : (row + GRID_SIZE - 1) % GRID_SIZE;
            if (wall_cells[row * GRID_SIZE + col]) begin
               res.hit          = 1'b1;
               res.hit_side     = gdda_pkg::SIDE_Y;
               res.hit_distance = side_y;
               res.hit_cell_x   = gdda_pkg::CELL_OUT_W'(col);
               res.hit_cell_y   = gdda_pkg::CELL_OUT_W'(row);
               return res;
            end
            side_y = side_y + it.step_dist_y;
         end
      end
      // no wall within the step limit: all-zero outcome
      return res;
   endfunction

   // ------------------------------------------------------------------
   // item builders
   // ------------------------------------------------------------------

   // gap length: mostly from the short range, now and then a long one
   function automatic int idle_gap();
      return ($urandom_range(99, 0) < 88) ? $urandom_range(3, 1) : $urandom_range(48, 10);
   endfunction

   // every field random, unused fields of an item included
   function automatic ray_item_type random_fill();
      ray_item_type it;
      it.kind        = 1'($urandom);
      it.cell_index  = gdda_pkg::IDX_W'($urandom);
      it.cell_wall   = 1'($urandom);
      it.pos_x       = gdda_pkg::POS_W'($urandom);
      it.pos_y       = gdda_pkg::POS_W'($urandom);
      it.frac_x_neg  = gdda_pkg::FRAC_W'($urandom);
      it.frac_x_pos  = gdda_pkg::FRAC_W'($urandom);
      it.frac_y_neg  = gdda_pkg::FRAC_W'($urandom);
      it.frac_y_pos  = gdda_pkg::FRAC_W'($urandom);
      it.step_dist_x = gdda_pkg::DIST_W'($urandom);
      it.step_dist_y = gdda_pkg::DIST_W'($urandom);
      it.quadrant    = gdda_pkg::QUAD_W'($urandom);
      return it;
   endfunction

   // in-cell fraction: mostly the nominal 0..256, sometimes anything in 9 bits
   function automatic logic [gdda_pkg::FRAC_W-1:0] random_frac();
      return ($urandom_range(99, 0) < 80) ? gdda_pkg::FRAC_W'($urandom_range(256, 0))
                                          : gdda_pkg::FRAC_W'($urandom);
   endfunction

   // step distance: small, full range, zero or near the top
   function automatic logic [gdda_pkg::DIST_W-1:0] random_step();
      int pick;
      pick = $urandom_range(99, 0);
      if (pick < 40) return gdda_pkg::DIST_W'($urandom_range(600, 1));
      if (pick < 80) return gdda_pkg::DIST_W'($urandom);
      if (pick < 90) return '0;
      return gdda_pkg::DIST_W'(65535 - $urandom_range(64, 0));
   endfunction

   function automatic ray_item_type random_cast();
      ray_item_type it;
      it             = random_fill();
      it.kind        = gdda_pkg::KIND_CAST;
      it.frac_x_neg  = random_frac();
      it.frac_x_pos  = random_frac();
      it.frac_y_neg  = random_frac();
      it.frac_y_pos  = random_frac();
      it.step_dist_x = random_step();
      it.step_dist_y = random_step();
      return it;
   endfunction

   function automatic ray_item_type random_write(input int wall_pct);
      ray_item_type it;
      it           = random_fill();
      it.kind      = gdda_pkg::KIND_WRITE;
      it.cell_wall = ($urandom_range(99, 0) < wall_pct);
      return it;
   endfunction

   // fixed-point position at the middle of a grid cell
   function automatic logic [gdda_pkg::POS_W-1:0] cell_center(input int c);
      return gdda_pkg::POS_W'(c * (1 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));
   endfunction

   // ------------------------------------------------------------------
   // sender: one item per call, then, by chance, a random gap
   // ------------------------------------------------------------------

   task automatic send_item(input ray_item_type it);
      int gap;
      req_valid       <= 1'b1;
      req_kind        <= it.kind;
      req_cell_index  <= it.cell_index;
      req_cell_wall   <= it.cell_wall;
      req_pos_x       <= it.pos_x;
      req_pos_y       <= it.pos_y;
      req_frac_x_neg  <= it.frac_x_neg;
      req_frac_x_pos  <= it.frac_x_pos;
      req_frac_y_neg  <= it.frac_y_neg;
      req_frac_y_pos  <= it.frac_y_pos;
      req_step_dist_x <= it.step_dist_x;
      req_step_dist_y <= it.step_dist_y;
      req_quadrant    <= it.quadrant;
      // stall is sampled as it stood before this edge
      do @(posedge clock); while (req_stall);
      // accepted at this edge: update the map or predict the outcome
      if (it.kind == gdda_pkg::KIND_WRITE) begin
         n_writes++;
         if (it.cell_index < CELL_COUNT) wall_cells[it.cell_index] = it.cell_wall;
      end else begin
         n_casts++;
         outcomes_due.push_back(trace_ray(it));
      end
      // valid stays high straight into the next item when there is no gap
      gap = ($urandom_range(99, 0) < send_gap_pct) ? idle_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_cell(input int row, input int col, input logic wall);
      ray_item_type it;
      it            = random_fill();
      it.kind       = gdda_pkg::KIND_WRITE;
      it.cell_index = gdda_pkg::IDX_W'(row * GRID_SIZE + col);
      it.cell_wall  = wall;
      send_item(it);
   endtask

   // cast from the middle of a cell; the fractions of the other direction get
   // the inverted value so a wrong quadrant pick shows up
   task automatic cast_ray(input int row, input int col,
                           input logic [gdda_pkg::QUAD_W-1:0] quad,
                           input logic [gdda_pkg::FRAC_W-1:0] fx,
                           input logic [gdda_pkg::FRAC_W-1:0] fy,
                           input logic [gdda_pkg::DIST_W-1:0] dx,
                           input logic [gdda_pkg::DIST_W-1:0] dy);
      ray_item_type it;
      it             = random_fill();
      it.kind        = gdda_pkg::KIND_CAST;
      it.pos_x       = cell_center(col);
      it.pos_y       = cell_center(row);
      it.quadrant    = quad;
      it.frac_x_pos  = quad[gdda_pkg::QUAD_X_POS_BIT] ? fx : ~fx;
      it.frac_x_neg  = quad[gdda_pkg::QUAD_X_POS_BIT] ? ~fx : fx;
      it.frac_y_pos  = quad[gdda_pkg::QUAD_Y_POS_BIT] ? fy : ~fy;
      it.frac_y_neg  = quad[gdda_pkg::QUAD_Y_POS_BIT] ? ~fy : fy;
      it.step_dist_x = dx;
      it.step_dist_y = dy;
      send_item(it);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // empty map: every cast walks the full step limit and misses
   task automatic test_empty_map();
      ray_item_type it;
      // all-zero cast: both sides tie at zero, y steps every time
      it      = '0;
      it.kind = gdda_pkg::KIND_CAST;
      send_item(it);
      // every field at its top value
      it          = '1;
      it.kind     = gdda_pkg::KIND_CAST;
      send_item(it);
      cast_ray(7, 7, TOWARD_XN_YP, 9'd100, 9'd200, 16'd900, 16'd300);
   endtask

   // walls placed by hand, hits on both sides, wrap, tie and overflow cases
   task automatic test_wall_hits();
      write_cell(5, 9, 1'b1);
      // +x along row 5 with y far away: x-side hit at column 9
      cast_ray(5, 5, TOWARD_XP_YN, 9'd128, 9'd128, 16'd256, 16'd65535);
      write_cell(1, 5, 1'b1);
      // -y up column 5: y-side hit at row 1
      cast_ray(5, 5, TOWARD_XN_YN, 9'd128, 9'd128, 16'd65535, 16'd256);
      // +x from the last column wraps to column 0
      write_cell(5, 0, 1'b1);
      cast_ray(5, GRID_SIZE - 1, TOWARD_XP_YN, 9'd64, 9'd255, 16'd256, 16'd65535);
      // -x from column 0 wraps to the last column
      write_cell(5, GRID_SIZE - 1, 1'b1);
      cast_ray(5, 0, TOWARD_XN_YP, 9'd200, 9'd256, 16'd256, 16'd65000);
      // fraction above the nominal 256
      cast_ray(5, 5, TOWARD_XP_YP, 9'd511, 9'd300, 16'd300, 16'd4000);
      // equal side distances: y wins the tie
      cast_ray(3, 5, TOWARD_XN_YN, 9'd128, 9'd128, 16'd512, 16'd512);
      // top step distances: side distances wrap at 16 bits
      cast_ray(5, 5, TOWARD_XP_YP, 9'd256, 9'd256, 16'd65535, 16'd65535);
      // last map index
      write_cell(GRID_SIZE - 1, GRID_SIZE - 1, 1'b1);
      cast_ray(GRID_SIZE - 1, GRID_SIZE - 2, TOWARD_XP_YN, 9'd10, 9'd256, 16'd100, 16'd60000);
      // wall removed: the ray now runs on to the wall at the last column
      write_cell(5, 9, 1'b0);
      cast_ray(5, 5, TOWARD_XP_YN, 9'd128, 9'd128, 16'd256, 16'd65535);
      // empty row: step limit reached without a hit
      cast_ray(10, 3, TOWARD_XP_YN, 9'd128, 9'd256, 16'd256, 16'd65535);
   endtask

   // random writes and casts over phases of different idling and wall density
   task automatic test_random_traffic();
      int gap_mix   [6] = '{0, 30, 70, 10, 50, 20};
      int stall_mix [6] = '{0, 30, 10, 70, 50, 20};
      int wall_mix  [6] = '{30, 15, 50, 5, 70, 25};
      for (int ph = 0; ph < 6; ph++) begin
         send_gap_pct = gap_mix[ph];
         stall_pct    = stall_mix[ph];
         for (int i = 0; i < 250; i++) begin
            if ($urandom_range(99, 0) < 35) send_item(random_write(wall_mix[ph]));
            else send_item(random_cast());
         end
      end
   endtask

   // receiver holds off for a long stretch while casts keep coming, so the
   // result register fills and the block stalls its input
   task automatic test_back_pressure();
      send_gap_pct = 0;
      stall_pct    = 0;
      hold_cycles  = HOLD_CYCLES;
      for (int i = 0; i < 80; i++) begin
         if ($urandom_range(99, 0) < 15) send_item(random_write(30));
         else send_item(random_cast());
      end
   endtask

   // back-to-back items with the receiver always ready
   task automatic test_steady_stream();
      send_gap_pct = 0;
      stall_pct    = 0;
      for (int i = 0; i < 400; i++) begin
         if ($urandom_range(99, 0) < 30) send_item(random_write(35));
         else send_item(random_cast());
      end
   endtask

   // ------------------------------------------------------------------
   // receiver pacing: random stall runs, or the requested long hold
   // ------------------------------------------------------------------

   initial begin : rsp_pacing
      int stall_run;
      stall_run = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else if (stall_run > 0) begin
            rsp_stall <= 1'b1;
            stall_run--;
         end else if ($urandom_range(99, 0) < stall_pct) begin
            rsp_stall <= 1'b1;
            stall_run = idle_gap() - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // result checking against the oldest prediction
   // ------------------------------------------------------------------

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         n_errors++;
         if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      ray_hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outcomes_due.size() == 0) begin
            n_errors++;
            $display("%0t: result with none expected, expected none, actual hit %0d dist %0d",
                     $time, rsp_hit, rsp_hit_distance);
         end else begin
            want = outcomes_due.pop_front();
            n_results++;
            if (want.hit) n_hits++;
            check_field("hit", want.hit, rsp_hit);
            check_field("hit_side", want.hit_side, rsp_hit_side);
            check_field("hit_distance", want.hit_distance, rsp_hit_distance);
            check_field("hit_cell_x", want.hit_cell_x, rsp_hit_cell_x);
            check_field("hit_cell_y", want.hit_cell_y, rsp_hit_cell_y);
         end
      end
   end

   // ------------------------------------------------------------------
   // watchdog: too long with nothing moving on either channel
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog, nothing moved for %0d cycles", $time, idle_cycles);
         $display("grid_ray_dda_traversal_top regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      // every input known from time zero
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = gdda_pkg::KIND_WRITE;
      req_cell_index  = '0;
      req_cell_wall   = 1'b0;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_frac_x_neg  = '0;
      req_frac_x_pos  = '0;
      req_frac_y_neg  = '0;
      req_frac_y_pos  = '0;
      req_step_dist_x = '0;
      req_step_dist_y = '0;
      req_quadrant    = '0;
      rsp_stall       = 1'b0;
      send_gap_pct    = 0;
      stall_pct       = 0;
      hold_cycles     = 0;
      n_writes        = 0;
      n_casts         = 0;
      n_results       = 0;
      n_hits          = 0;
      n_errors        = 0;
      idle_cycles     = 0;
      foreach (wall_cells[i]) wall_cells[i] = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // first item waits out the clearing pass behind req_stall
      test_empty_map();
      test_wall_hits();
      test_random_traffic();
      test_back_pressure();
      test_steady_stream();

      req_valid <= 1'b0;
      stall_pct = 20;
      // drain outstanding casts; the watchdog covers a hang
      while (outcomes_due.size() != 0) @(posedge clock);
      stall_pct = 0;
      // room for a stray extra result to show up
      repeat (MAX_STEPS + 10) @(posedge clock);

      $display("covered %0d map writes and %0d casts, %0d results checked (%0d hits)",
               n_writes, n_casts, n_results, n_hits);
      $display("idling mixes: six random phases, a %0d-cycle receiver hold, a gap-free stream",
               HOLD_CYCLES);
      if (n_errors == 0 && outcomes_due.size() == 0) begin
         $display("grid_ray_dda_traversal_top regression: pass");
      end else begin
         $display("grid_ray_dda_traversal_top regression: fail");
      end
      $finish;
   end

endmodule
